/* design/iri_pkg.sv */
// Package: shared types and constants of the IRI-to-URI percent encoder.
`default_nettype none
package iri_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // One classified job: up to three held bytes and then the current byte.
  typedef struct packed {
    logic [2:0][7:0] pend;       // held bytes, index 0 first
    logic [7:0]      cur_byte;   // the byte of this input
    logic [1:0]      pend_n;     // how many held bytes to emit
    logic            emit_cur;   // emit cur_byte after the held bytes
    logic            enc;        // percent-encode every emitted byte
  } job_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] PERCENT   = 8'h25;
  localparam logic [7:0] ASCII_0   = 8'h30;
  localparam logic [7:0] ASCII_A10 = 8'h37;  // 'A' - 10
  localparam logic [3:0] HEX_NINE  = 4'd9;

  // Slot code of the current byte in the back end (held bytes use 0..2).
  localparam logic [1:0] SLOT_CUR  = 2'd3;
  localparam logic [1:0] PHASE_LO  = 2'd2;

endpackage
`default_nettype wire

/* design/iri_to_uri_percent_encoder_top.sv */
// Top level: IRI-to-URI percent encoder, front end, job queue and back end.
// Path: an input transaction is written into the job queue, then loaded into
//   the back-end job register, and the first output byte is then valid.
// Output: one output byte per cycle from the back end while out_ready is high;
//   an ASCII or raw byte gives one output byte, each byte of an encoded character
//   three (one input gives 1 to 12 output bytes, or none while a character is open).
// Reset: synchronous rst empties the queue, drops the open character and
//   idles the back end; no input is taken while rst is high.
`default_nettype none
module iri_to_uri_percent_encoder_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iri_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output iri_pkg::out_t      out_item
);

  // Front to queue.
  logic          push;
  iri_pkg::job_t push_job;
  logic          not_full;

  // Queue to back.
  logic          q_valid;
  iri_pkg::job_t q_job;
  logic          q_pop;

  logic          in_ready_raw;

  // The front end decodes UTF-8 and turns each input transaction into at
  // most one job: held bytes plus the current byte, raw or encoded.
  iri_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready_raw),
    .in_item   (in_item),
    .job_valid (push),
    .job       (push_job),
    .job_ready (not_full)
  );

  // Hold input off during reset.
  assign in_ready = in_ready_raw && !rst;

  // Short queue lets the front keep accepting while the back expands.
  iri_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !rst),
    .push_job  (push_job),
    .not_full  (not_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  // The back end walks the job one output byte per cycle while out_ready is high,
  // and marks the final byte of each job with last_of_run.
  iri_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_in    (q_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* design/iri_front.sv */
// Front end: UTF-8 decode state, classification and job generation.
`default_nettype none
module iri_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iri_pkg::in_t  in_item,
  output logic               job_valid,
  output iri_pkg::job_t      job,
  input  wire logic          job_ready
);

  logic [2:0][7:0] pend;
  logic [1:0]      pcount;
  logic [2:0]      exp_len;
  logic [20:0]     acc;

  logic [2:0][7:0] pend_next;
  logic [1:0]      pcount_next;
  logic [2:0]      exp_len_next;
  logic [20:0]     acc_next;

  logic [7:0]  b;
  logic        eot;
  logic        is_cont;
  logic        is_lead;
  logic [20:0] acc_cont;
  logic        take;

  function automatic logic needs_enc(input logic [20:0] cp);
    logic [4:0]  plane;
    logic [15:0] low;
    logic        r;
    plane = cp[20:16];
    low   = cp[15:0];
    r     = 1'b0;
    if (cp inside {[21'h0000A0:21'h00D7FF], [21'h00E000:21'h00F8FF],
                   [21'h00F900:21'h00FDCF], [21'h00FDF0:21'h00FFEF]}) begin
      r = 1'b1;
    end else if (plane inside {[5'd1:5'd13], 5'd15, 5'd16}) begin
      r = (low <= 16'hFFFD);
    end else if (plane == 5'd14) begin
      r = (low >= 16'h1000) && (low <= 16'hFFFD);
    end
    return r;
  endfunction

  assign b        = in_item.in_byte;
  assign eot      = in_item.end_of_text;
  assign is_cont  = (b[7:6] == 2'b10);
  assign is_lead  = (b >= 8'hC0) && (b <= 8'hF7);
  assign acc_cont = {acc[14:0], b[5:0]};
  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    pend_next    = pend;
    pcount_next  = pcount;
    exp_len_next = exp_len;
    acc_next     = acc;
    job.pend     = pend;
    job.cur_byte = b;
    job.pend_n   = 2'd0;
    job.emit_cur = 1'b0;
    job.enc      = 1'b0;

    if (pcount != 2'd0 && is_cont) begin
      acc_next = acc_cont;
      if ({1'b0, pcount} + 3'd1 >= exp_len) begin
        // character complete
        job.pend_n   = pcount;
        job.emit_cur = 1'b1;
        job.enc      = needs_enc(acc_cont);
        pcount_next  = 2'd0;
      end else if (eot) begin
        job.pend_n   = pcount;
        job.emit_cur = 1'b1;
        pcount_next  = 2'd0;
      end else begin
        pend_next[pcount] = b;
        pcount_next       = pcount + 2'd1;
      end
    end else begin
      // held bytes of a cut-short character go out raw first
      job.pend_n  = pcount;
      pcount_next = 2'd0;
      if (is_lead && !eot) begin
        pend_next[0] = b;
        pcount_next  = 2'd1;
        if (b <= 8'hDF) begin
          exp_len_next = 3'd2;
          acc_next     = {16'd0, b[4:0]};
        end else if (b <= 8'hEF) begin
          exp_len_next = 3'd3;
          acc_next     = {17'd0, b[3:0]};
        end else begin
          exp_len_next = 3'd4;
          acc_next     = {18'd0, b[2:0]};
        end
      end else begin
        job.emit_cur = 1'b1;
      end
    end
  end

  assign job_valid = take && ((job.pend_n != 2'd0) || job.emit_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      pcount  <= 2'd0;
      exp_len <= 3'd0;
      acc     <= 21'd0;
    end else if (take) begin
      pend    <= pend_next;
      pcount  <= pcount_next;
      exp_len <= exp_len_next;
      acc     <= acc_next;
    end
  end

endmodule
`default_nettype wire

/* design/iri_queue.sv */
// Job queue between the front end and the back end.
`default_nettype none
module iri_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire iri_pkg::job_t push_job,
  output logic               not_full,
  output logic               pop_valid,
  output iri_pkg::job_t      pop_job,
  input  wire logic          pop
);

  iri_pkg::job_t             mem [iri_pkg::QueueDepth];
  logic [iri_pkg::QPtrW-1:0] wptr;
  logic [iri_pkg::QPtrW-1:0] rptr;
  logic [iri_pkg::QCntW-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign not_full  = (count != iri_pkg::QCntW'(iri_pkg::QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_job   = mem[rptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == iri_pkg::QPtrW'(iri_pkg::QueueDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == iri_pkg::QPtrW'(iri_pkg::QueueDepth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/iri_back.sv */
// Back end: expands one job into output bytes, one per cycle while out_ready is high.
`default_nettype none
module iri_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire iri_pkg::job_t job_in,
  output logic               job_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output iri_pkg::out_t      out_item
);

  iri_pkg::job_t job;
  logic          busy;
  logic [1:0]    slot;
  logic [1:0]    phase;

  logic [7:0] cur;
  logic       step_done;
  logic       slot_final;
  logic       is_last;
  logic       fire;
  logic [2:0] slot_inc;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v <= iri_pkg::HEX_NINE) ? iri_pkg::ASCII_0 + {4'd0, v}
                                    : iri_pkg::ASCII_A10 + {4'd0, v};
  endfunction

  assign cur        = (slot == iri_pkg::SLOT_CUR) ? job.cur_byte : job.pend[slot];
  assign step_done  = !job.enc || (phase == iri_pkg::PHASE_LO);
  assign slot_inc   = {1'b0, slot} + 3'd1;
  assign slot_final = (slot == iri_pkg::SLOT_CUR) ||
                      ((slot_inc >= {1'b0, job.pend_n}) && !job.emit_cur);
  assign is_last    = step_done && slot_final;
  assign fire       = busy && out_ready;
  assign job_pop    = job_valid && (!busy || (out_ready && is_last));

  assign out_valid = busy;

  always_comb begin
    out_item.last_of_run = is_last;
    if (!job.enc) begin
      out_item.out_byte = cur;
    end else begin
      case (phase)
        2'd0:    out_item.out_byte = iri_pkg::PERCENT;
        2'd1:    out_item.out_byte = hex_digit(cur[7:4]);
        default: out_item.out_byte = hex_digit(cur[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      slot  <= 2'd0;
      phase <= 2'd0;
    end else if (job_pop) begin
      busy  <= 1'b1;
      slot  <= (job_in.pend_n == 2'd0) ? iri_pkg::SLOT_CUR : 2'd0;
      phase <= 2'd0;
    end else if (fire) begin
      if (is_last) begin
        busy <= 1'b0;
      end else if (step_done) begin
        phase <= 2'd0;
        slot  <= (slot_inc < {1'b0, job.pend_n}) ? slot_inc[1:0] : iri_pkg::SLOT_CUR;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire
